@@ src/image_block_downscaler_unit_assert.svh @@
// Assertion helpers for the downscaler.
`ifndef IMAGE_BLOCK_DOWNSCALER_UNIT_ASSERT_SVH
`define IMAGE_BLOCK_DOWNSCALER_UNIT_ASSERT_SVH
`define IBD_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication failed");
`define IBD_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

@@ src/ibd_pkg.sv @@
`default_nettype none
package ibd_pkg;
  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxFactor = 16;
  localparam int unsigned LineLimit    = 4096;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 13;

  localparam logic [CfgIdxW-1:0] RegScale  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd2;
  localparam logic [CfgIdxW-1:0] RegColor  = 2'd3;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_row;
    logic       end_of_frame;
  } pix_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic rd_en;      // read partial sums of the current pixel's column
    logic wr_en;      // write back the accumulated sum
    logic load_out;   // reduced pixel goes to the output register
  } ctl_cmd_t;

  // Per-pixel tags carried with the read.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [1:0] wt;      // weight: 0,1,2,4 coded as shift 0..2 with zero flag
    logic       wzero;
    logic       rgb;
    logic       eor;
    logic       eof;
  } pix_tag_t;
endpackage
`default_nettype wire

@@ src/ibd_ram.sv @@
`default_nettype none
module ibd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/ibd_ctrl.sv @@
`default_nettype none
module ibd_ctrl #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxFactor = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ibd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ibd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       out_busy_i,
  output ibd_pkg::ctl_cmd_t               cmd_o,
  output ibd_pkg::pix_tag_t               tag_o,
  output logic [$clog2(MaxWidth/2)-1:0]   addr_o,
  output logic [$clog2(MaxFactor+1)-1:0]  factor_o
);
  import ibd_pkg::*;
  localparam int unsigned AW  = $clog2(MaxWidth/2);
  localparam int unsigned PW  = $clog2(LineLimit > MaxWidth ? LineLimit : MaxWidth) + 1;
  localparam int unsigned FW  = $clog2(MaxFactor+1);

  typedef enum logic [2:0] {
    StIdle = 3'b001, StRead = 3'b010, StWrite = 3'b100
  } state_e;
  state_e state_q, state_d;

  logic [4:0]  scale_q;
  logic [12:0] width_q, height_q;
  logic        color_q;
  logic [PW-1:0] x_q, y_q, bx_q;
  logic [FW-1:0] cx_q, ry_q;

  logic [FW-1:0] f;
  logic [PW-1:0] w, h;
  always_comb begin
    f = (scale_q == 5'd0) ? FW'(1) :
        ({27'd0, scale_q} > MaxFactor) ? FW'(MaxFactor) : FW'(scale_q);
    w = (width_q == 13'd0) ? PW'(1) :
        ({19'd0, width_q} > MaxWidth) ? PW'(MaxWidth) : PW'(width_q);
    h = (height_q == 13'd0) ? PW'(1) :
        ({19'd0, height_q} > LineLimit) ? PW'(LineLimit) : PW'(height_q);
  end

  // Pixel extent of full blocks per line and frame, compared with x and y.
  logic [PW-1:0] out_w_end, out_h_end;   // x/y limits of full blocks
  logic [PW-1:0] bx_w_q, by_h_q;
  logic          lim_rdy_q;
  // Limits computed once per config by repeated addition.
  logic [PW-1:0] acc_q;
  logic [1:0]    lphase_q;
  assign out_w_end = bx_w_q;
  assign out_h_end = by_h_q;

  logic accept, in_range, cx_last, ry_last, x_wrap, y_wrap;
  assign in_stall_o = !(state_q == StIdle) || !lim_rdy_q;
  assign accept = in_valid_i && !in_stall_o;
  assign in_range = (x_q < out_w_end) && (y_q < out_h_end);
  assign cx_last = (cx_q == f - FW'(1));
  assign ry_last = (ry_q == f - FW'(1));
  assign x_wrap = (x_q + PW'(1) >= w);
  assign y_wrap = (y_q + PW'(1) >= h);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept && in_range) state_d = StRead;
      StRead:  state_d = StWrite;
      // Hold a finished block until the output register is free.
      StWrite: if (!(tag_o.last && out_busy_i)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic [1:0] wsh;
  logic       wz;
  always_comb begin
    wsh = 2'd0;
    wz  = 1'b0;
    if (f == FW'(3)) wsh = 2'((ry_q == FW'(1)) ? 1 : 0) + 2'((cx_q == FW'(1)) ? 1 : 0);
    else if (f[0]) wz = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      scale_q <= 5'd2; width_q <= 13'd4096; height_q <= 13'd4096; color_q <= 1'b0;
      x_q <= '0; y_q <= '0; cx_q <= '0; ry_q <= '0; bx_q <= '0;
      lim_rdy_q <= 1'b0; lphase_q <= 2'd0; acc_q <= '0;
      bx_w_q <= '0; by_h_q <= '0;
      tag_o <= '0; addr_o <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegScale:  scale_q  <= cfg_data_i[4:0];
          RegWidth:  width_q  <= cfg_data_i;
          RegHeight: height_q <= cfg_data_i;
          RegColor:  color_q  <= cfg_data_i[0];
          default: ;
        endcase
        x_q <= '0; y_q <= '0; cx_q <= '0; ry_q <= '0; bx_q <= '0;
        lim_rdy_q <= 1'b0; lphase_q <= 2'd0;
      end else if (!lim_rdy_q) begin
        // Find floor(w/f)*f and floor(h/f)*f by stepping f at a time.
        unique case (lphase_q)
          2'd0: begin acc_q <= PW'(f); lphase_q <= 2'd1; end
          2'd1: if (acc_q > w) begin
                  bx_w_q <= acc_q - PW'(f); acc_q <= PW'(f); lphase_q <= 2'd2;
                end else acc_q <= acc_q + PW'(f);
          2'd2: if (acc_q > h) begin
                  by_h_q <= acc_q - PW'(f); lim_rdy_q <= 1'b1; lphase_q <= 2'd0;
                end else acc_q <= acc_q + PW'(f);
          default: lphase_q <= 2'd0;
        endcase
      end else if (accept) begin
        tag_o.first <= (cx_q == '0) && (ry_q == '0);
        tag_o.last  <= cx_last && ry_last;
        tag_o.wt    <= wsh;
        tag_o.wzero <= wz;
        tag_o.rgb   <= color_q;
        tag_o.eor   <= (x_q + PW'(1) == out_w_end);
        tag_o.eof   <= (x_q + PW'(1) == out_w_end) && (y_q + PW'(1) == out_h_end);
        addr_o      <= AW'(bx_q);
        if (cx_last || x_wrap) begin
          cx_q <= '0;
          bx_q <= bx_q + PW'(cx_last ? 1 : 0);
        end else cx_q <= cx_q + FW'(1);
        x_q <= x_q + PW'(1);
        if (x_wrap) begin
          x_q <= '0; bx_q <= '0;
          ry_q <= ry_last ? '0 : ry_q + FW'(1);
          y_q <= y_q + PW'(1);
          if (y_wrap) begin y_q <= '0; ry_q <= '0; end
        end
      end
    end
  end

  assign cmd_o.rd_en    = (state_q == StRead);
  assign cmd_o.wr_en    = (state_q == StWrite);
  assign cmd_o.load_out = (state_q == StWrite) && tag_o.last && !out_busy_i;
  assign factor_o = f;
endmodule
`default_nettype wire

@@ src/ibd_datapath.sv @@
`default_nettype none
module ibd_datapath #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxFactor = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ibd_pkg::pix_in_t          in_data_i,
  input  wire logic                      in_accept_i,
  input  wire ibd_pkg::ctl_cmd_t         cmd_i,
  input  wire ibd_pkg::pix_tag_t         tag_i,
  input  wire logic [$clog2(MaxWidth/2)-1:0]  addr_i,
  input  wire logic [$clog2(MaxFactor+1)-1:0] factor_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output ibd_pkg::pix_out_t              out_data_o
);
  import ibd_pkg::*;
  localparam int unsigned FW = $clog2(MaxFactor+1);

  pix_in_t pix_q;
  logic [15:0] rd_r, rd_g, rd_b, s_r, s_g, s_b;
  always_ff @(posedge clk_i) if (in_accept_i) pix_q <= in_data_i;

  function automatic logic [15:0] acc(input logic [15:0] old, input logic [7:0] v,
                                      input pix_tag_t t, input logic en);
    logic [15:0] p;
    p = t.wzero || !en ? 16'd0 : ({8'd0, v} << t.wt);
    return (t.first ? 16'd0 : old) + p;
  endfunction

  assign s_r = acc(rd_r, pix_q.red_in,   tag_i, 1'b1);
  assign s_g = acc(rd_g, pix_q.green_in, tag_i, tag_i.rgb);
  assign s_b = acc(rd_b, pix_q.blue_in,  tag_i, tag_i.rgb);

  ibd_ram #(.Width(16), .Depth(MaxWidth/2)) u_r (.clk_i, .we_i(cmd_i.wr_en),
    .waddr_i(addr_i), .wdata_i(s_r), .re_i(cmd_i.rd_en), .raddr_i(addr_i), .rdata_o(rd_r));
  ibd_ram #(.Width(16), .Depth(MaxWidth/2)) u_g (.clk_i, .we_i(cmd_i.wr_en),
    .waddr_i(addr_i), .wdata_i(s_g), .re_i(cmd_i.rd_en), .raddr_i(addr_i), .rdata_o(rd_g));
  ibd_ram #(.Width(16), .Depth(MaxWidth/2)) u_b (.clk_i, .we_i(cmd_i.wr_en),
    .waddr_i(addr_i), .wdata_i(s_b), .re_i(cmd_i.rd_en), .raddr_i(addr_i), .rdata_o(rd_b));

  // Even f: mean over f*f from a table of reciprocals, ceil(2^24 / f*f), exact for
  // 16-bit sums (a power of two for f = 2,4,8,16). f = 3: sum/16; other odd: 0.
  function automatic logic [7:0] reduce(input logic [15:0] s, input logic [FW-1:0] f);
    logic [38:0] m;
    logic [22:0] rc;
    rc = 23'd0;
    unique case (f)
      FW'(2):  rc = 23'd4194304;  FW'(4):  rc = 23'd1048576;
      FW'(6):  rc = 23'd466034;   FW'(8):  rc = 23'd262144;
      FW'(10): rc = 23'd167773;   FW'(12): rc = 23'd116509;
      FW'(14): rc = 23'd85599;    FW'(16): rc = 23'd65536;
      default: rc = 23'd0;
    endcase
    m = {23'd0, s} * {16'd0, rc};
    if (f == FW'(3)) return s[11:4];
    if (f[0] || rc == 23'd0) return 8'd0;
    return m[31:24];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.load_out) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_o.red_out      <= reduce(s_r, factor_i);
      out_data_o.green_out    <= tag_i.rgb ? reduce(s_g, factor_i) : 8'd0;
      out_data_o.blue_out     <= tag_i.rgb ? reduce(s_b, factor_i) : 8'd0;
      out_data_o.end_of_row   <= tag_i.eor;
      out_data_o.end_of_frame <= tag_i.eof;
    end
  end
endmodule
`default_nettype wire

@@ src/image_block_downscaler_unit.sv @@
`default_nettype none
// An accepted in-block pixel takes a read and a write step on the sum RAM
// port, and no new pixel is taken until the write step ends; a block's result
// beat is registered from its last pixel's write step. Edge pixels outside full
// blocks are dropped in the idle state. A block's last pixel stays in the write
// step while the previous result beat is still held. Reset and every register
// write restart the frame; block limits are found before any pixel is taken.
module image_block_downscaler_unit #(
  parameter int unsigned MaxWidth  = ibd_pkg::DefMaxWidth,
  parameter int unsigned MaxFactor = ibd_pkg::DefMaxFactor
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ibd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ibd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire ibd_pkg::pix_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output ibd_pkg::pix_out_t               out_data_o
);
  import ibd_pkg::*;
`include "image_block_downscaler_unit_assert.svh"
  ctl_cmd_t cmd;
  pix_tag_t tag;
  logic [$clog2(MaxWidth/2)-1:0]  addr;
  logic [$clog2(MaxFactor+1)-1:0] factor;

  ibd_ctrl #(.MaxWidth(MaxWidth), .MaxFactor(MaxFactor)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .out_busy_i(out_valid_o), .cmd_o(cmd), .tag_o(tag), .addr_o(addr), .factor_o(factor));

  ibd_datapath #(.MaxWidth(MaxWidth), .MaxFactor(MaxFactor)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .in_accept_i(in_valid_i && !in_stall_o),
    .cmd_i(cmd), .tag_i(tag), .addr_i(addr), .factor_i(factor),
    .out_valid_o, .out_stall_i, .out_data_o);

  `IBD_ASSERT_NXT(a_rd_then_wr, clk_i, rst_ni, cmd.rd_en, cmd.wr_en)
  `IBD_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, cmd.rd_en || cmd.wr_en, in_stall_o)
  `IBD_ASSERT_NXT(a_load_valid, clk_i, rst_ni, cmd.load_out, out_valid_o)
endmodule
`default_nettype wire

@@ tb/sv/image_block_downscaler_unit_tb.sv @@
`timescale 1ns / 1ps
module image_block_downscaler_unit_tb;
  import ibd_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = RegScale;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pix_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pix_out_t            out_data_o;

  always #5 clk_i = ~clk_i;

  image_block_downscaler_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // Shadow copy of the block: registers, per-column sums and raster position.
  int unsigned sh_factor, sh_width, sh_height, sh_color;
  int unsigned sum_r[2048], sum_g[2048], sum_b[2048];
  int unsigned col_pos, line_pos, col_blk, line_blk;
  pix_out_t    pending_pixels[$];
  int          errors = 0;
  bit          hold_off = 1'b0;
  bit          fixed_check;
  pix_out_t    fixed_pixel;
  pix_out_t    exp_pix;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned shrink(int unsigned s, int unsigned f);
    if (f % 2 == 0) return (s / (f * f)) & 8'hff;
    if (f == 3) return (s / 16) & 8'hff;
    return 0;
  endfunction

  function automatic void restart_position();
    col_pos = 0; line_pos = 0; col_blk = 0; line_blk = 0;
  endfunction

  function automatic void set_shadow_reg(logic [CfgIdxW-1:0] idx, int unsigned v);
    case (idx)
      RegScale:  sh_factor = v & 5'h1f;
      RegWidth:  sh_width  = v & 13'h1fff;
      RegHeight: sh_height = v & 13'h1fff;
      RegColor:  sh_color  = v & 1;
      default: ;
    endcase
    restart_position();
  endfunction

  // Advance the shadow by one pixel; push the block result when one completes.
  function automatic void predict_pixel(pix_in_t p);
    int unsigned f, w, h, ow, oh, bx, r, g, b, wt;
    bit rgb, first, eor;
    pix_out_t o;
    f = (sh_factor == 0) ? 1 : ((sh_factor > DefMaxFactor) ? DefMaxFactor : sh_factor);
    w = clamp_dim(sh_width, DefMaxWidth);
    h = clamp_dim(sh_height, LineLimit);
    ow = w / f; oh = h / f;
    rgb = sh_color != 0;
    if (col_pos < ow * f && line_pos < oh * f) begin
      bx = col_pos / f;
      r = p.red_in;
      g = rgb ? p.green_in : 0;
      b = rgb ? p.blue_in : 0;
      wt = 1;
      if (f == 3) wt = (line_blk == 1 ? 2 : 1) * (col_blk == 1 ? 2 : 1);
      else if (f % 2 == 1) wt = 0;
      if (bx < 2048) begin
        first = (col_blk == 0 && line_blk == 0);
        sum_r[bx] = ((first ? 0 : sum_r[bx]) + r * wt) & 16'hffff;
        sum_g[bx] = ((first ? 0 : sum_g[bx]) + g * wt) & 16'hffff;
        sum_b[bx] = ((first ? 0 : sum_b[bx]) + b * wt) & 16'hffff;
      end
      if (col_blk == f - 1 && line_blk == f - 1) begin
        eor = (bx == ow - 1);
        o.red_out      = 8'(shrink((bx < 2048) ? sum_r[bx] : 0, f));
        o.green_out    = rgb ? 8'(shrink((bx < 2048) ? sum_g[bx] : 0, f)) : 8'd0;
        o.blue_out     = rgb ? 8'(shrink((bx < 2048) ? sum_b[bx] : 0, f)) : 8'd0;
        o.end_of_row   = eor;
        o.end_of_frame = eor && (line_pos / f == oh - 1);
        pending_pixels.push_back(o);
      end
    end
    col_blk = (col_blk + 1 >= f) ? 0 : col_blk + 1;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0; col_blk = 0;
      line_blk = (line_blk + 1 >= f) ? 0 : line_blk + 1;
      line_pos++;
      if (line_pos >= h) begin
        line_pos = 0; line_blk = 0;
      end
    end
  endfunction

  // Output side: stall for a randomly drawn gap before each beat, and while held off.
  initial begin : output_side
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3);
      while (gap != 0 || hold_off) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
        if (gap != 0) gap--;
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data_o);
        errors++;
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (fixed_check && exp_pix != fixed_pixel) begin
          $display("%0t: table value %h, predicted %h", $time, fixed_pixel, exp_pix);
          errors++;
        end
        fixed_check = 1'b0;
        if (out_data_o.red_out != exp_pix.red_out ||
            out_data_o.green_out != exp_pix.green_out ||
            out_data_o.blue_out != exp_pix.blue_out ||
            out_data_o.end_of_row != exp_pix.end_of_row ||
            out_data_o.end_of_frame != exp_pix.end_of_frame) begin
          $display("%0t: expected %h, got %h", $time, exp_pix, out_data_o);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(pix_in_t p);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    predict_pixel(p);
  endtask

  task automatic drain();
    int unsigned n;
    in_valid_i <= 1'b0;
    n = 0;
    while (pending_pixels.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    set_shadow_reg(idx, v);
  endtask

  task automatic setup(int unsigned f, int unsigned w, int unsigned h, int unsigned c);
    write_reg(RegScale, f);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegColor, c);
  endtask

  task automatic send_frame(int unsigned n);
    pix_in_t p;
    repeat (n) begin
      p = 24'($urandom);
      if ($urandom_range(0, 7) == 0) p = '1;
      else if ($urandom_range(0, 7) == 0) p = '0;
      send_pixel(p);
    end
  endtask

  typedef struct {
    pix_in_t  pix;
    bit       has_fixed;
    pix_out_t fixed;
  } row_t;

  initial begin : stimulus
    row_t rows[$];
    row_t rw;
    int unsigned f, w, h, npix;
    sh_factor = 2; sh_width = 4096; sh_height = 4096; sh_color = 0;
    restart_position();
    fixed_check = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 2x2 RGB frame of full-scale pixels, 3x3 Gaussian, odd factor,
    // factor zero and out-of-range registers, grayscale ignoring green/blue.
    setup(2, 2, 2, 1);
    repeat (3) begin
      rw.pix = '1; rw.has_fixed = 0; rows.push_back(rw);
    end
    rw.pix = '1; rw.has_fixed = 1; rw.fixed = {8'hff, 8'hff, 8'hff, 1'b1, 1'b1};
    rows.push_back(rw);
    foreach (rows[i]) begin
      if (rows[i].has_fixed) begin
        fixed_check = 1'b1; fixed_pixel = rows[i].fixed;
      end
      send_pixel(rows[i].pix);
    end
    rows.delete();
    setup(3, 3, 3, 1);
    repeat (9) begin
      rw.pix = 24'($urandom); rw.has_fixed = 0; rows.push_back(rw);
    end
    foreach (rows[i]) send_pixel(rows[i].pix);
    setup(5, 5, 5, 0);
    send_frame(25);
    setup(0, 2, 1, 0);
    send_frame(2);
    setup(31, 8191, 1, 0);
    send_frame(40);
    setup(2, 0, 0, 0);
    send_frame(1);
    setup(16, 16, 16, 1);
    send_frame(256);
    setup(2, 3, 3, 0);
    send_frame(9);

    // Long receiver hold-off so the block backs up on its input.
    setup(2, 8, 4, 1);
    hold_off = 1'b1;
    fork
      send_frame(32);
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join

    // Random frames, mostly small.
    npix = 0;
    while (npix < 300) begin
      f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom_range(2, 4);
      w = $urandom_range(1, 13);
      h = $urandom_range(1, 10);
      setup(f, w, h, $urandom_range(0, 1));
      send_frame(w * h);
      npix += w * h;
    end
    drain();
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
